// File: rtl/core/clr_pkg.sv
package clr_pkg;

	localparam int COORD_W = 8;
	localparam int PIX_W   = 6;
	localparam int GLYPH_W = 8;
	localparam int ERR_W   = 10;
	localparam int CNT_W   = 6;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [COORD_W-1:0]        delta_t;
	typedef logic [PIX_W-1:0]          pix_t;
	typedef logic [GLYPH_W-1:0]        glyph_t;
	typedef logic signed [ERR_W-1:0]   err_t;
	typedef logic [CNT_W-1:0]          cnt_t;

	localparam glyph_t GLYPH_RESET = 8'd35;

	// controller to datapath
	typedef struct packed {
		logic load;   // latch line endpoints
		logic setup;  // work out deltas, directions and first error term
		logic step;   // advance one point along the line
		logic emit;   // load the output register from the current point
	} clr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic at_end;   // current point is the endpoint
		logic emit_ok;  // current point is on screen and below the result cap
	} clr_sts_t;

endpackage

// File: rtl/core/clr_line_if.sv
interface clr_line_if import clr_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, output ready);
endinterface

// File: rtl/core/clr_pixel_if.sv
interface clr_pixel_if import clr_pkg::*; ();
	logic   valid;
	logic   ready;
	pix_t   pixel_x;
	pix_t   pixel_y;
	glyph_t pixel_glyph;
	logic   visible;
	logic   last;

	modport source (output valid, output pixel_x, output pixel_y, output pixel_glyph,
		output visible, output last, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input pixel_glyph,
		input visible, input last, output ready);
endinterface

// File: rtl/core/clr_ctrl.sv
module clr_ctrl import clr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_ready,
	output logic     out_valid,
	output clr_cmd_t cmd,
	input  clr_sts_t sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SETUP,
		S_WALK
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_step;

	// output register free, or its transaction completes this cycle
	assign can_step  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == S_IDLE) && in_valid;
		cmd.setup = (state_q == S_SETUP);
		cmd.step  = (state_q == S_WALK) && can_step && !sts.at_end;
		cmd.emit  = (state_q == S_WALK) && can_step && (sts.at_end || sts.emit_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SETUP;
				end
				S_SETUP: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (can_step && sts.at_end) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken one");

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && can_step && sts.at_end) |=> (state_q == S_IDLE && out_valid_q))
		else $error("endpoint step did not finish the line");

	a_load_to_setup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_SETUP))
		else $error("accepted line not set up");

endmodule

// File: rtl/core/clr_datapath.sv
module clr_datapath import clr_pkg::*; #(
	parameter int SCREEN_W = 32,
	parameter int SCREEN_H = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  glyph_t   cfg_wdata,
	input  coord_t   start_x,
	input  coord_t   start_y,
	input  coord_t   end_x,
	input  coord_t   end_y,
	input  clr_cmd_t cmd,
	output clr_sts_t sts,
	output pix_t     pixel_x,
	output pix_t     pixel_y,
	output glyph_t   pixel_glyph,
	output logic     visible,
	output logic     last
);

	coord_t walk_x_q, walk_y_q, end_x_q, end_y_q;
	delta_t dx_q, dy_q;
	logic   sx_neg_q, sy_neg_q;
	err_t   err_q;
	cnt_t   cnt_q;
	glyph_t glyph_q;
	pix_t   px_q, py_q;
	glyph_t pg_q;
	logic   vis_q, last_q;

	logic signed [COORD_W:0] diff_x, diff_y, abs_x, abs_y;
	logic signed [ERR_W:0]   e2, neg_dy, dx_ext, dy_ext, err_sum;
	logic                    cx, cy, vis, at_end;

	// setup arithmetic
	assign diff_x = {end_x_q[COORD_W-1], end_x_q} - {walk_x_q[COORD_W-1], walk_x_q};
	assign diff_y = {end_y_q[COORD_W-1], end_y_q} - {walk_y_q[COORD_W-1], walk_y_q};
	assign abs_x  = diff_x[COORD_W] ? -diff_x : diff_x;
	assign abs_y  = diff_y[COORD_W] ? -diff_y : diff_y;

	// step decision, e2 = 2 * error term
	assign dx_ext  = $signed({{(ERR_W+1-COORD_W){1'b0}}, dx_q});
	assign dy_ext  = $signed({{(ERR_W+1-COORD_W){1'b0}}, dy_q});
	assign e2      = {err_q, 1'b0};
	assign neg_dy  = -dy_ext;
	assign cx      = e2 > neg_dy;
	assign cy      = e2 < dx_ext;
	assign err_sum = {err_q[ERR_W-1], err_q} - (cx ? dy_ext : '0) + (cy ? dx_ext : '0);

	assign vis = !walk_x_q[COORD_W-1] && (walk_x_q[COORD_W-2:0] < (COORD_W-1)'(SCREEN_W))
		&& !walk_y_q[COORD_W-1] && (walk_y_q[COORD_W-2:0] < (COORD_W-1)'(SCREEN_H));
	assign at_end = (walk_x_q == end_x_q) && (walk_y_q == end_y_q);

	assign sts.at_end  = at_end;
	assign sts.emit_ok = vis && (cnt_q != '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_q <= GLYPH_RESET;
		end else if (cfg_we) begin
			glyph_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			walk_x_q <= start_x;
			walk_y_q <= start_y;
			end_x_q  <= end_x;
			end_y_q  <= end_y;
			cnt_q    <= '0;
		end
		if (cmd.setup) begin
			dx_q     <= abs_x[COORD_W-1:0];
			dy_q     <= abs_y[COORD_W-1:0];
			sx_neg_q <= diff_x[COORD_W] || (diff_x == '0);
			sy_neg_q <= diff_y[COORD_W] || (diff_y == '0);
			err_q    <= ERR_W'($signed({2'b00, abs_x[COORD_W-1:0]})
				- $signed({2'b00, abs_y[COORD_W-1:0]}));
		end
		if (cmd.step) begin
			err_q <= err_sum[ERR_W-1:0];
			if (cx) walk_x_q <= sx_neg_q ? walk_x_q - 1'b1 : walk_x_q + 1'b1;
			if (cy) walk_y_q <= sy_neg_q ? walk_y_q - 1'b1 : walk_y_q + 1'b1;
		end
		if (cmd.emit) begin
			px_q   <= vis ? walk_x_q[PIX_W-1:0] : '0;
			py_q   <= vis ? walk_y_q[PIX_W-1:0] : '0;
			pg_q   <= glyph_q;
			vis_q  <= vis;
			last_q <= at_end;
			if (!at_end) cnt_q <= cnt_q + 1'b1;
		end
	end

	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_glyph = pg_q;
	assign visible     = vis_q;
	assign last        = last_q;

endmodule

// File: rtl/core/clipped_line_rasterizer.sv
// Operation: a line is taken in IDLE, set up in SETUP, then walked at one point per cycle
// while the output register can take a result; the first result is registered at the
// earliest from the first WALK state. No new line is taken before the endpoint step, and
// each walk step waits while the single output register still holds an untaken result.
// Reset: arst_n clears the controller and the output valid at once; glyph returns to 35.
module clipped_line_rasterizer import clr_pkg::*; #(
	parameter int SCREEN_W = 32,
	parameter int SCREEN_H = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	clr_line_if.sink    line,
	clr_pixel_if.source pixel,
	input  logic   cfg_we,
	input  glyph_t cfg_wdata
);

	clr_cmd_t cmd;
	clr_sts_t sts;

	// Controller: IDLE -> SETUP -> WALK, one walk point per cycle while the output
	// register can take a result. It owns the handshakes and the output valid.
	clr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (line.valid),
		.in_ready  (line.ready),
		.out_ready (pixel.ready),
		.out_valid (pixel.valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath: endpoints, deltas, error term, walk point, clipping test,
	// result counter, glyph register and the output payload register.
	clr_datapath #(
		.SCREEN_W (SCREEN_W),
		.SCREEN_H (SCREEN_H)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.start_x     (line.start_x),
		.start_y     (line.start_y),
		.end_x       (line.end_x),
		.end_y       (line.end_y),
		.cmd         (cmd),
		.sts         (sts),
		.pixel_x     (pixel.pixel_x),
		.pixel_y     (pixel.pixel_y),
		.pixel_glyph (pixel.pixel_glyph),
		.visible     (pixel.visible),
		.last        (pixel.last)
	);

	// one line at a time: no second transaction straight after an accept
	a_single_line: assert property (@(posedge clk) disable iff (!arst_n)
		(line.valid && line.ready) |=> !line.ready)
		else $error("line accepted while walking");

	// an off-screen endpoint result carries zero coordinates
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && !pixel.visible) |-> (pixel.pixel_x == '0 && pixel.pixel_y == '0))
		else $error("hidden result with coordinates");

	// visible results lie on the screen
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.visible) |->
		(PIX_W'(SCREEN_W) > pixel.pixel_x && PIX_W'(SCREEN_H) > pixel.pixel_y))
		else $error("visible result off screen");

	// a pending mid-line result means the walk is still running
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && !pixel.last) |-> !line.ready)
		else $error("idle with a mid-line result pending");

endmodule

// File: bench/tb_clipped_line_rasterizer.sv
`timescale 1ns / 1ps

// Line rasteriser bench. Line requests go in through the line channel and pixel
// transactions come back on the pixel channel. A behavioural tracer walks each accepted
// line and queues the pixels it should produce, and the sink side pops and compares
// them field by field. The glyph register is rewritten only once the block has drained.
module tb_clipped_line_rasterizer;
	import clr_pkg::*;

	localparam int SCREEN_W      = 32;
	localparam int SCREEN_H      = 32;
	localparam int MAX_PIXELS    = 64;   // hard cap on transactions per line
	localparam int WALK_GUARD    = 512;  // step limit of the walk, never reached in practice
	localparam int IDLE_PCT      = 19;   // chance in a hundred of a gap or a stall
	localparam int SETTLE_CYCLES = 8;    // quiet time after the last pixel of a phase
	localparam int HOLD_CYCLES   = 400;  // long sink hold-off that backs the block up
	localparam int RANDOM_LINES  = 240;

	typedef struct {
		pix_t   x;
		pix_t   y;
		glyph_t glyph;
		logic   visible;
		logic   last;
	} pixel_rec_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   cfg_we;
	glyph_t cfg_wdata;

	clr_line_if  line_ch();
	clr_pixel_if pixel_ch();

	clipped_line_rasterizer #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.line     (line_ch),
		.pixel    (pixel_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	glyph_t     glyph_shadow;      // what the glyph register should hold
	pixel_rec_t pending_pixels[$]; // pixels still owed by the block, oldest first
	int         fail_count = 0;
	bit         steady     = 1'b0; // no gaps on either side while set
	bit         sink_hold  = 1'b0; // sink refuses every pixel while set

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Walk one line with the integer error term and queue every pixel it should give.
	// On-screen points before the endpoint are queued unless the cap is hit; the endpoint
	// is always queued, marked last, with coordinates zeroed when it lies off screen.
	function automatic void trace_line(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
		int         cx, cy, tx, ty;
		int         dx, dy, sx, sy;
		int         err, e2, emitted, guard;
		bit         vis, done;
		pixel_rec_t rec;
		cx = x0;
		cy = y0;
		tx = x1;
		ty = y1;
		dx = (tx > cx) ? tx - cx : cx - tx;
		dy = (ty > cy) ? ty - cy : cy - ty;
		sx = (cx < tx) ? 1 : -1;
		sy = (cy < ty) ? 1 : -1;
		err = dx - dy;
		emitted = 0;
		guard = 0;
		done = 1'b0;
		while (!done) begin
			vis = cx >= 0 && cx < SCREEN_W && cy >= 0 && cy < SCREEN_H;
			rec.x       = vis ? pix_t'(cx) : '0;
			rec.y       = vis ? pix_t'(cy) : '0;
			rec.glyph   = glyph_shadow;
			rec.visible = vis;
			if ((cx == tx && cy == ty) || guard >= WALK_GUARD) begin
				rec.last = 1'b1;
				pending_pixels.push_back(rec);
				done = 1'b1;
			end else begin
				e2 = 2 * err;
				if (vis && emitted < MAX_PIXELS - 1) begin
					rec.last = 1'b0;
					pending_pixels.push_back(rec);
					emitted++;
				end
				if (e2 > -dy) begin
					err -= dy;
					cx += sx;
				end
				if (e2 < dx) begin
					err += dx;
					cy += sy;
				end
				guard++;
			end
		end
	endfunction

	// Offer one line and return at the edge that takes it. Valid is left high, so a
	// following call at the same time step just replaces the fields; anything that lets
	// time pass without a new line must drop valid first.
	task automatic send_line(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			line_ch.valid <= 1'b0;
			@(posedge clk);
		end
		line_ch.valid   <= 1'b1;
		line_ch.start_x <= x0;
		line_ch.start_y <= y0;
		line_ch.end_x   <= x1;
		line_ch.end_y   <= y1;
		@(posedge clk);
		while (!line_ch.ready)
			@(posedge clk);
		trace_line(x0, y0, x1, y1);
	endtask

	// Sender pause: nothing offered until every owed pixel is back and the block is idle.
	task automatic wait_for_pixels();
		line_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called with the block drained; the model picks the new glyph up at the write edge.
	task automatic write_glyph(glyph_t g);
		cfg_we    <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		glyph_shadow = g;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Around the screen, with a margin on every side so that clipping happens often.
	function automatic coord_t near_coord();
		return coord_t'(int'($urandom_range(47)) - 8);
	endfunction

	function automatic coord_t any_coord();
		return coord_t'($urandom_range(255));
	endfunction

	// Mostly lines that touch the screen; some from far away, some anywhere, some short.
	task automatic send_random_line();
		coord_t x0, y0, x1, y1;
		int     kind;
		kind = $urandom_range(9);
		x0 = near_coord();
		y0 = near_coord();
		x1 = near_coord();
		y1 = near_coord();
		if (kind == 5 || kind == 6) begin
			x1 = any_coord();
			y1 = any_coord();
			if (kind == 6) begin
				{x0, x1} = {x1, x0};
				{y0, y1} = {y1, y0};
			end
		end else if (kind == 7 || kind == 8) begin
			x0 = any_coord();
			y0 = any_coord();
			x1 = any_coord();
			y1 = any_coord();
		end else if (kind == 9) begin
			x0 = coord_t'($urandom_range(SCREEN_W - 1));
			y0 = coord_t'($urandom_range(SCREEN_H - 1));
			x1 = x0 + coord_t'(int'($urandom_range(6)) - 3);
			y1 = y0 + coord_t'(int'($urandom_range(6)) - 3);
		end
		send_line(x0, y0, x1, y1);
	endtask

	// Extremes, all eight octants, pure horizontals and verticals, degenerate lines on
	// and off screen, endpoints on the screen corners and just past them. Reset glyph.
	task automatic test_directed_lines();
		coord_t lines[23][4] = '{
			'{5, 5, 5, 5},
			'{-1, -1, -1, -1},
			'{127, 127, 127, 127},
			'{-128, -128, -128, -128},
			'{-128, 3, 127, 3},
			'{127, 20, -128, 20},
			'{10, -128, 10, 127},
			'{25, 127, 25, -128},
			'{16, 16, 30, 20},
			'{16, 16, 20, 30},
			'{16, 16, 12, 30},
			'{16, 16, 2, 20},
			'{16, 16, 2, 12},
			'{16, 16, 12, 2},
			'{16, 16, 20, 2},
			'{16, 16, 30, 12},
			'{0, 0, 31, 31},
			'{31, 0, 0, 31},
			'{-128, -128, 127, 127},
			'{127, -128, -128, 127},
			'{0, 0, 32, 32},
			'{-5, 10, 40, 12},
			'{40, 40, 31, 31}
		};
		foreach (lines[i])
			send_line(lines[i][0], lines[i][1], lines[i][2], lines[i][3]);
		wait_for_pixels();
	endtask

	task automatic test_glyph_extremes();
		glyph_t extremes[2] = '{8'h00, 8'hFF};
		foreach (extremes[i]) begin
			write_glyph(extremes[i]);
			repeat (3) send_random_line();
			wait_for_pixels();
		end
	endtask

	// The sink holds off for a long stretch in a process of its own while lines keep
	// coming: the output register fills, the walk stalls and the line input backs up.
	task automatic test_output_backpressure();
		fork
			begin
				sink_hold = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold = 1'b0;
			end
		join_none
		send_line(-4, 2, 36, 29);
		send_line(30, -6, 1, 37);
		send_line(3, 3, 28, 4);
		send_line(20, 35, 21, -3);
		send_line(0, 31, 31, 0);
		wait_for_pixels();
	endtask

	// Random lines, with a fresh glyph at each pause and a stretch without any gaps.
	task automatic test_random_lines();
		for (int i = 0; i < RANDOM_LINES; i++) begin
			if (i % 60 == 59) begin
				wait_for_pixels();
				write_glyph(glyph_t'($urandom_range(255)));
			end
			steady = (i >= 90 && i < 150);
			send_random_line();
		end
		steady = 1'b0;
		wait_for_pixels();
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Sink side: take a pixel transaction, compare with the oldest owed pixel, then
	// decide ready for the next edge.
	always @(posedge clk) begin
		pixel_rec_t want;
		if (arst_n && pixel_ch.valid && pixel_ch.ready) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel transaction with none owed: x %0d y %0d last %0b",
					pixel_ch.pixel_x, pixel_ch.pixel_y, pixel_ch.last);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("pixel_x", want.x, pixel_ch.pixel_x);
				check_field("pixel_y", want.y, pixel_ch.pixel_y);
				check_field("pixel_glyph", want.glyph, pixel_ch.pixel_glyph);
				check_field("visible", want.visible, pixel_ch.visible);
				check_field("last", want.last, pixel_ch.last);
			end
		end
		pixel_ch.ready <= !sink_hold && (steady || $urandom_range(99) >= IDLE_PCT);
	end

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		line_ch.valid   = 1'b0;
		line_ch.start_x = '0;
		line_ch.start_y = '0;
		line_ch.end_x   = '0;
		line_ch.end_y   = '0;
		pixel_ch.ready  = 1'b0;
		glyph_shadow    = GLYPH_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_lines();
		test_glyph_extremes();
		test_output_backpressure();
		test_random_lines();

		if (fail_count == 0)
			$display("clipped_line_rasterizer test passed");
		else
			$display("clipped_line_rasterizer test failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#10000000;
		$display("clipped_line_rasterizer test failed");
		$finish;
	end

endmodule
